[hdl/ihr_pkg.sv]
// ----------------------------------------------------------------------------
// ihr_pkg
// Shared types and constants for the Intel HEX record checker: beat
// payloads, the classified character that crosses the queue, status codes.
// ----------------------------------------------------------------------------
package ihr_pkg;

  // Data bytes accepted per record
  localparam int IHR_MAX_DATA    = 32;
  // Depth of the queue between front and back
  localparam int IHR_QUEUE_DEPTH = 2;
  // Shortest legal record: colon, count, address, type, checksum
  localparam int IHR_MIN_LEN     = 11;
  // Character position counter
  localparam int IHR_POS_W       = 10;
  localparam int IHR_POS_MAX     = 1023;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT        = 3'd1,
    ST_NO_COLON     = 3'd2,
    ST_BAD_DIGIT    = 3'd3,
    ST_OVER_CAP     = 3'd4,
    ST_LEN_MISMATCH = 3'd5,
    ST_CHECKSUM     = 3'd6
  } status_t;

  // First error seen in the record; late means a bad digit after the header
  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_COLON = 3'd2,
    ERR_HEAD  = 3'd3,
    ERR_LATE  = 3'd7
  } err_t;

  typedef struct packed {
    logic [7:0] record_char;
    logic       last_char;
  } char_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    status_t     status;
    logic [7:0]  byte_count;
    logic [15:0] load_address;
    logic [7:0]  record_type;
  } result_item_t;

  // Classified character, as queued between front and back
  typedef struct packed {
    logic [3:0] nibble;
    logic       hex_ok;
    logic       colon;
    logic       last_char;
  } class_item_t;

endpackage

[hdl/ihr_front.sv]
// ----------------------------------------------------------------------------
// ihr_front
// Accepts character beats and classifies them: hex digit value in either
// case, digit flag, colon flag. Pushes the result into the queue.
// ----------------------------------------------------------------------------
module ihr_front (
  input  logic                char_valid,
  output logic                char_stall,
  input  ihr_pkg::char_item_t char_data,
  input  logic                q_full,
  output logic                push,
  output ihr_pkg::class_item_t push_item
);
  import ihr_pkg::*;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  logic [7:0] c;

  assign c          = char_data.record_char;
  assign char_stall = q_full;
  assign push       = char_valid && !q_full;

  always_comb begin
    push_item.colon     = (c == CH_COLON);
    push_item.last_char = char_data.last_char;
    push_item.hex_ok    = 1'b1;
    push_item.nibble    = 4'd0;
    priority if (c >= CH_ZERO && c <= CH_NINE) begin
      push_item.nibble = 4'(c - CH_ZERO);
    end else if (c >= CH_UA && c <= CH_UF) begin
      push_item.nibble = 4'(c - CH_UA + HEX_TEN);
    end else if (c >= CH_LA && c <= CH_LF) begin
      push_item.nibble = 4'(c - CH_LA + HEX_TEN);
    end else begin
      push_item.hex_ok = 1'b0;
    end
  end

endmodule

[hdl/ihr_queue.sv]
// ----------------------------------------------------------------------------
// ihr_queue
// Short FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
module ihr_queue #(
  parameter int QUEUE_DEPTH = ihr_pkg::IHR_QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  ihr_pkg::class_item_t                 push_item,
  input  logic                                 pop,
  output ihr_pkg::class_item_t                 head,
  output logic                                 q_valid,
  output logic                                 q_full,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     q_count
);
  import ihr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  class_item_t      entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head    = entries[rd_ptr];
  assign q_valid = (count != '0);
  assign q_full  = (count == CNT_FULL);
  assign q_count = count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/ihr_back.sv]
// ----------------------------------------------------------------------------
// ihr_back
// Carries out the record state: pairs digits into bytes, keeps the running
// checksum, captures header fields, emits data bytes and the final status.
// ----------------------------------------------------------------------------
module ihr_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  ihr_pkg::class_item_t  head,
  output logic                  pop,
  output logic                  result_valid,
  input  logic                  result_stall,
  output ihr_pkg::result_item_t result
);
  import ihr_pkg::*;

  localparam logic [IHR_POS_W-1:0] POS_COUNT  = IHR_POS_W'(2);
  localparam logic [IHR_POS_W-1:0] POS_ADDR_H = IHR_POS_W'(4);
  localparam logic [IHR_POS_W-1:0] POS_ADDR_L = IHR_POS_W'(6);
  localparam logic [IHR_POS_W-1:0] POS_TYPE   = IHR_POS_W'(8);
  localparam logic [IHR_POS_W-1:0] POS_DATA   = IHR_POS_W'(10);
  localparam logic [IHR_POS_W-1:0] POS_LIMIT  = IHR_POS_W'(IHR_POS_MAX);
  localparam logic [IHR_POS_W:0]   LEN_MIN    = (IHR_POS_W+1)'(IHR_MIN_LEN);
  localparam logic [7:0]           CAP        = 8'(IHR_MAX_DATA);

  logic [IHR_POS_W-1:0] char_position, char_position_next;
  logic [3:0]           high_nibble, high_nibble_next;
  logic [7:0]           running_sum, running_sum_next;
  logic [7:0]           count_field, count_field_next;
  logic [15:0]          address_field, address_field_next;
  logic [7:0]           type_field, type_field_next;
  err_t                 first_error, first_error_next;

  logic [7:0]           pair_byte;
  logic [IHR_POS_W-1:0] data_pos;
  logic [IHR_POS_W:0]   total_len;
  logic [IHR_POS_W:0]   expect_len;
  logic                 emit_data;
  status_t              st;
  result_item_t         result_next;

  assign pop        = q_valid && (!result_valid || !result_stall);
  assign pair_byte  = {high_nibble, head.nibble};
  assign data_pos   = (char_position - POS_DATA) >> 1;
  assign total_len  = {1'b0, char_position} + 1'b1;
  assign expect_len = LEN_MIN + {{(IHR_POS_W-8){1'b0}}, count_field_next, 1'b0};

  always_comb begin
    high_nibble_next   = high_nibble;
    running_sum_next   = running_sum;
    count_field_next   = count_field;
    address_field_next = address_field;
    type_field_next    = type_field;
    first_error_next   = first_error;
    emit_data          = 1'b0;

    if (char_position == '0) begin
      if (!head.colon && first_error == ERR_NONE) begin
        first_error_next = ERR_COLON;
      end
    end else begin
      if (!head.hex_ok && first_error == ERR_NONE) begin
        first_error_next = (char_position <= POS_TYPE) ? ERR_HEAD : ERR_LATE;
      end
      if (char_position[0]) begin
        high_nibble_next = head.nibble;
      end else begin
        running_sum_next = running_sum + pair_byte;
        priority if (char_position == POS_COUNT) begin
          count_field_next = pair_byte;
        end else if (char_position == POS_ADDR_H) begin
          address_field_next[15:8] = pair_byte;
        end else if (char_position == POS_ADDR_L) begin
          address_field_next[7:0] = pair_byte;
        end else if (char_position == POS_TYPE) begin
          type_field_next = pair_byte;
        end else if (char_position >= POS_DATA) begin
          emit_data = (data_pos < {{(IHR_POS_W-8){1'b0}}, count_field}) &&
                      (first_error_next == ERR_NONE) && (count_field <= CAP);
        end else begin
          emit_data = 1'b0;
        end
      end
    end

    char_position_next = (char_position < POS_LIMIT) ? char_position + 1'b1 : char_position;

    priority if (total_len < LEN_MIN) begin
      st = ST_SHORT;
    end else if (first_error_next == ERR_COLON) begin
      st = ST_NO_COLON;
    end else if (first_error_next == ERR_HEAD) begin
      st = ST_BAD_DIGIT;
    end else if (count_field_next > CAP) begin
      st = ST_OVER_CAP;
    end else if (total_len != expect_len) begin
      st = ST_LEN_MISMATCH;
    end else if (first_error_next == ERR_LATE) begin
      st = ST_BAD_DIGIT;
    end else if (running_sum_next != 8'd0) begin
      st = ST_CHECKSUM;
    end else begin
      st = ST_OK;
    end

    result_next = '0;
    if (head.last_char) begin
      result_next.kind         = KIND_STATUS;
      result_next.status       = st;
      result_next.byte_count   = (st == ST_OK) ? count_field_next : 8'd0;
      result_next.load_address = address_field_next;
      result_next.record_type  = type_field_next;
    end else begin
      result_next.kind       = KIND_DATA;
      result_next.data_byte  = pair_byte;
      result_next.data_index = data_pos[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      high_nibble   <= '0;
      running_sum   <= '0;
      count_field   <= '0;
      address_field <= '0;
      type_field    <= '0;
      first_error   <= ERR_NONE;
    end else if (pop) begin
      if (head.last_char) begin
        char_position <= '0;
        high_nibble   <= '0;
        running_sum   <= '0;
        count_field   <= '0;
        address_field <= '0;
        type_field    <= '0;
        first_error   <= ERR_NONE;
      end else begin
        char_position <= char_position_next;
        high_nibble   <= high_nibble_next;
        running_sum   <= running_sum_next;
        count_field   <= count_field_next;
        address_field <= address_field_next;
        type_field    <= type_field_next;
        first_error   <= first_error_next;
      end
    end
  end

  // Output register: valid clears under reset, payload loads on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= head.last_char || emit_data;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

endmodule

[hdl/intel_hex_record_checker_unit.sv]
// Path: an accepted character beat is written into the queue, then the back stage
//   loads its result beat into the output register.
// Throughput: one character per cycle unless result_stall holds; the back stage
//   settles one character per cycle, the output register frees as its beat is taken.
// Reset (rst, synchronous): empties the queue, drops any pending result and
//   rearms the record state at position zero with no error.
// ----------------------------------------------------------------------------
// intel_hex_record_checker_unit
// Intel HEX record checker: takes one record character per beat, emits each data
// byte up to the first error if within capacity, and a final status beat per record.
// ----------------------------------------------------------------------------
module intel_hex_record_checker_unit #(
  parameter int QUEUE_DEPTH = ihr_pkg::IHR_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  // character channel
  input  logic                  char_valid,
  output logic                  char_stall,
  input  ihr_pkg::char_item_t   char_data,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output ihr_pkg::result_item_t result
);
  import ihr_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Front to queue
  logic        push;
  class_item_t push_item;
  logic        q_full;

  // Queue to back
  class_item_t      head;
  logic             q_valid;
  logic             pop;
  logic [CNT_W-1:0] q_count;

  // Front: classify each character, stall only when the queue is full
  ihr_front u_front (
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  // Queue: decouple front stalls from back stalls
  ihr_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_count   (q_count)
  );

  // Back: advance the record state and drive the output register
  ihr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Queue occupancy never passes its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  // An accepted character beat is held in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !char_stall) |=> (q_count != '0))
    else $error("accepted beat missing from queue");

  // An error status never reports a byte count
  a_err_no_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_STATUS && result.status != ST_OK)
      |-> (result.byte_count == 8'd0))
    else $error("byte count on error status");

  // Data bytes only at indexes within capacity
  a_data_in_cap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_DATA)
      |-> (result.data_index < 8'(IHR_MAX_DATA)))
    else $error("data index beyond capacity");

endmodule

[test/ihr_record_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihr_record_monitor
// Watches the character and result channels of the record checker, predicts
// each result beat from the accepted characters and compares field by field.
// ----------------------------------------------------------------------------
module ihr_record_monitor (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  input  logic                  char_stall,
  input  ihr_pkg::char_item_t   char_data,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  ihr_pkg::result_item_t result,
  output int                    fail_count,
  output int                    pending_results
);
  import ihr_pkg::*;

  // Record state as the checker should hold it
  logic [IHR_POS_W-1:0] rec_pos;
  logic [3:0]           rec_high;
  logic [7:0]           rec_sum;
  logic [7:0]           rec_count;
  logic [15:0]          rec_addr;
  logic [7:0]           rec_type;
  err_t                 rec_err;

  result_item_t expected_beats[$];
  int           mismatches = 0;

  task automatic clear_record();
    rec_pos   = '0;
    rec_high  = '0;
    rec_sum   = '0;
    rec_count = '0;
    rec_addr  = '0;
    rec_type  = '0;
    rec_err   = ERR_NONE;
  endtask

  // Advance the record by one character; queue the beat it causes, if any.
  task automatic decode_record_char(input char_item_t beat);
    logic [7:0]   c;
    logic [3:0]   nib;
    logic         is_hex;
    logic [7:0]   b;
    logic         emit;
    int           p;
    int           idx;
    int           total;
    status_t      st;
    result_item_t r;
    c    = beat.record_char;
    p    = int'(rec_pos);
    emit = 1'b0;
    r    = '0;
    if (p == 0) begin
      if (c != ":" && rec_err == ERR_NONE) rec_err = ERR_COLON;
    end else begin
      is_hex = 1'b1;
      if (c >= "0" && c <= "9") nib = 4'(c - "0");
      else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
      else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
      else begin
        is_hex = 1'b0;
        nib    = 4'd0;
      end
      // only the first error of a record sticks
      if (!is_hex && rec_err == ERR_NONE) rec_err = (p <= 8) ? ERR_HEAD : ERR_LATE;
      if (p % 2 == 1) begin
        rec_high = nib;
      end else begin
        b       = {rec_high, nib};
        rec_sum = rec_sum + b;
        case (p)
          2: rec_count = b;
          4: rec_addr[15:8] = b;
          6: rec_addr[7:0] = b;
          8: rec_type = b;
          default: begin
            idx = (p - 10) / 2;
            if (idx < rec_count && rec_err == ERR_NONE && rec_count <= IHR_MAX_DATA) begin
              emit         = 1'b1;
              r.kind       = KIND_DATA;
              r.data_byte  = b;
              r.data_index = idx[7:0];
            end
          end
        endcase
      end
    end
    if (p < IHR_POS_MAX) rec_pos = rec_pos + 1'b1;

    if (beat.last_char) begin
      total = p + 1;
      if (total < IHR_MIN_LEN) st = ST_SHORT;
      else if (rec_err == ERR_COLON) st = ST_NO_COLON;
      else if (rec_err == ERR_HEAD) st = ST_BAD_DIGIT;
      else if (rec_count > IHR_MAX_DATA) st = ST_OVER_CAP;
      else if (total != IHR_MIN_LEN + 2 * rec_count) st = ST_LEN_MISMATCH;
      else if (rec_err == ERR_LATE) st = ST_BAD_DIGIT;
      else if (rec_sum != 8'd0) st = ST_CHECKSUM;
      else st = ST_OK;
      r              = '0;
      r.kind         = KIND_STATUS;
      r.status       = st;
      r.byte_count   = (st == ST_OK) ? rec_count : 8'd0;
      r.load_address = rec_addr;
      r.record_type  = rec_type;
      expected_beats.push_back(r);
      clear_record();
    end else if (emit) begin
      expected_beats.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_item_t want;
    if (rst) begin
      clear_record();
      expected_beats.delete();
    end else begin
      // a result beat can never come from the character taken at the same edge
      if (result_valid && !result_stall) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result beat, expected none, actual %h", $time, result);
        end else begin
          want = expected_beats.pop_front();
          check_field("kind", 16'(want.kind), 16'(result.kind));
          check_field("data_byte", 16'(want.data_byte), 16'(result.data_byte));
          check_field("data_index", 16'(want.data_index), 16'(result.data_index));
          check_field("status", 16'(want.status), 16'(result.status));
          check_field("byte_count", 16'(want.byte_count), 16'(result.byte_count));
          check_field("load_address", want.load_address, result.load_address);
          check_field("record_type", 16'(want.record_type), 16'(result.record_type));
        end
      end
      if (char_valid && !char_stall) decode_record_char(char_data);
    end
    fail_count      <= mismatches;
    pending_results <= expected_beats.size();
  end

endmodule

[test/intel_hex_record_checker_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intel_hex_record_checker_unit_test
// Feeds Intel HEX record text into the checker one character per beat:
// a directed set of edge cases, then random well-formed and damaged records
// under several idle and stall patterns. A separate monitor predicts and
// compares every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module intel_hex_record_checker_unit_test;
  import ihr_pkg::*;

  // Random characters to send after the directed part, split over four phases
  localparam int RANDOM_CHARS   = 600;
  // Length of the receiver hold-off that backs the block up
  localparam int LONG_HOLD      = 300;
  // Cycles with no beat on either channel before the run is called hung
  localparam int WATCHDOG_LIMIT = 4000;
  // Quiet cycles at the end to catch any stray result beat
  localparam int DRAIN_CYCLES   = 10;

  // Shapes of random record
  typedef enum int {
    REC_GOOD,
    REC_BAD_SUM,
    REC_NO_COLON,
    REC_BAD_DIGIT,
    REC_TRUNC,
    REC_EXTEND,
    REC_OVER_CAP,
    REC_SHORT,
    REC_NOISE
  } rec_form_t;

  logic         clk;
  logic         rst;
  logic         char_valid;
  logic         char_stall;
  char_item_t   char_data;
  logic         result_valid;
  logic         result_stall;
  result_item_t result;

  int fail_count;
  int pending_results;

  // Idle and stall odds in percent, set per phase
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int chars_sent    = 0;
  int idle_cycles   = 0;

  // Toggle hold_req to start one long receiver hold-off
  bit hold_req  = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  intel_hex_record_checker_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_data   (char_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  ihr_record_monitor u_monitor (
    .clk            (clk),
    .rst            (rst),
    .char_valid     (char_valid),
    .char_stall     (char_stall),
    .char_data      (char_data),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One hex digit as text, in either case
  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
    if (nib < 4'd10) return "0" + nib;
    return (lower ? "a" : "A") + nib - 8'd10;
  endfunction

  // Build the text of a record: colon, count, address, type, cnt random data
  // bytes, checksum. skew is what the bytes sum to, so zero gives a clean sum.
  // Every digit gets its case at random.
  task automatic build_record(input int cnt, input logic [15:0] adr, input logic [7:0] typ,
                              input logic [7:0] skew, output logic [7:0] txt[$]);
    logic [7:0] fields[$];
    logic [7:0] sum;
    fields.push_back(cnt[7:0]);
    fields.push_back(adr[15:8]);
    fields.push_back(adr[7:0]);
    fields.push_back(typ);
    repeat (cnt) fields.push_back(8'($urandom_range(255)));
    sum = 8'd0;
    foreach (fields[i]) sum += fields[i];
    fields.push_back(skew - sum);
    txt.delete();
    txt.push_back(":");
    foreach (fields[i]) begin
      txt.push_back(hex_char(fields[i][7:4], 1'($urandom_range(1))));
      txt.push_back(hex_char(fields[i][3:0], 1'($urandom_range(1))));
    end
  endtask

  // Send a record one character beat at a time, flagging the last one.
  // Idle gaps come before each beat at the phase's odds; a stalled beat holds.
  task automatic send_text(input logic [7:0] txt[$]);
    for (int i = 0; i < txt.size(); i++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        char_valid <= 1'b0;
        @(posedge clk);
      end
      char_valid <= 1'b1;
      char_data  <= '{record_char: txt[i], last_char: (i == txt.size() - 1)};
      @(posedge clk);
      while (char_stall) @(posedge clk);
      chars_sent++;
    end
  endtask

  // Receiver: random stall at the phase's odds, or a long hold-off on request.
  // The hold-off is counted here so the sender keeps offering beats meanwhile.
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: end the run when no beat moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] txt[$];
    logic [7:0] c;
    rec_form_t  form;
    int         pick;
    int         cnt;
    int         n;
    int         target;

    rst        <= 1'b1;
    char_valid <= 1'b0;
    char_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- Directed part ----
    // Empty record with type 01: the usual end-of-file line
    build_record(0, 16'h0000, 8'h01, 8'h00, txt);
    send_text(txt);
    // One data byte at the top address with the top type
    build_record(1, 16'hFFFF, 8'hFF, 8'h00, txt);
    send_text(txt);
    // A lone colon that ends the record at once: too short
    txt.delete();
    txt.push_back(":");
    send_text(txt);
    // Sound record with the colon missing
    build_record(2, 16'($urandom), 8'($urandom), 8'h00, txt);
    txt[0] = "x";
    send_text(txt);
    // Bad digit in the low nibble of the type: still inside the header
    build_record(0, 16'($urandom), 8'($urandom), 8'h00, txt);
    txt[8] = "G";
    send_text(txt);
    // Bad digit in the first checksum digit: just past the header
    build_record(0, 16'($urandom), 8'($urandom), 8'h00, txt);
    txt[9] = "g";
    send_text(txt);
    // Checksum off by one
    build_record(2, 16'($urandom), 8'($urandom), 8'h01, txt);
    send_text(txt);
    // Count of 255 with only a header's worth of text: over capacity wins
    build_record(255, 16'($urandom), 8'($urandom), 8'h00, txt);
    while (txt.size() > IHR_MIN_LEN) void'(txt.pop_back());
    send_text(txt);
    // One character short of the length the count asks for
    build_record(3, 16'($urandom), 8'($urandom), 8'h00, txt);
    void'(txt.pop_back());
    send_text(txt);
    // Overlong run of digits, far past what its count of one asks for
    txt.delete();
    txt.push_back(":");
    txt.push_back("0");
    txt.push_back("1");
    repeat (2 * IHR_MAX_DATA)
      txt.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
    send_text(txt);
    // Full-capacity record right after, to show the checker rearmed
    build_record(IHR_MAX_DATA, 16'($urandom), 8'($urandom), 8'h00, txt);
    send_text(txt);

    // ---- Random part ----
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 80;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 80;
        end
        default: begin
          send_idle_pct = 31;
          stall_pct     = 31;
        end
      endcase

      if (phase == 0) begin
        // Hold off the receiver while full records keep coming, so the block
        // backs up and stalls its character input
        hold_req = ~hold_req;
        repeat (3) begin
          build_record(IHR_MAX_DATA, 16'($urandom), 8'($urandom), 8'h00, txt);
          send_text(txt);
        end
      end

      target = chars_sent + RANDOM_CHARS / 4;
      while (chars_sent < target) begin
        // Mostly clean records, the rest damaged in one way each
        pick = $urandom_range(99);
        if (pick < 55) form = REC_GOOD;
        else if (pick < 62) form = REC_BAD_SUM;
        else if (pick < 67) form = REC_NO_COLON;
        else if (pick < 75) form = REC_BAD_DIGIT;
        else if (pick < 81) form = REC_TRUNC;
        else if (pick < 86) form = REC_EXTEND;
        else if (pick < 90) form = REC_OVER_CAP;
        else if (pick < 95) form = REC_SHORT;
        else form = REC_NOISE;

        // Keep most records small; full capacity now and then
        pick = $urandom_range(99);
        if (pick < 70) cnt = $urandom_range(6);
        else if (pick < 95) cnt = $urandom_range(IHR_MAX_DATA - 1, 7);
        else cnt = IHR_MAX_DATA;
        if (form == REC_OVER_CAP) cnt = $urandom_range(IHR_MAX_DATA + 4, IHR_MAX_DATA + 1);

        build_record(cnt, 16'($urandom),
                     8'($urandom_range(1) ? $urandom_range(5) : $urandom_range(255)),
                     8'((form == REC_BAD_SUM) ? $urandom_range(255, 1) : 0), txt);

        case (form)
          REC_NO_COLON: begin
            do c = 8'($urandom_range(255)); while (c == ":");
            txt[0] = c;
          end
          REC_BAD_DIGIT: begin
            // any non-hex code, upper half of the byte range included
            do c = 8'($urandom_range(255));
            while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
                   (c >= "a" && c <= "f"));
            txt[$urandom_range(txt.size() - 1, 1)] = c;
          end
          REC_TRUNC: begin
            n = $urandom_range(6, 1);
            repeat (n) void'(txt.pop_back());
          end
          REC_EXTEND: begin
            n = $urandom_range(4, 1);
            repeat (n)
              txt.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
          end
          REC_SHORT: begin
            n = $urandom_range(IHR_MIN_LEN - 1, 1);
            while (txt.size() > n) void'(txt.pop_back());
          end
          REC_NOISE: begin
            n = $urandom_range(24, 1);
            txt.delete();
            repeat (n) txt.push_back(8'($urandom_range(255)));
            if ($urandom_range(1)) txt[0] = ":";
          end
          default: ;
        endcase
        send_text(txt);
      end
    end

    // Drop valid, wait for every predicted beat, then a short quiet spell
    char_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_results == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
